### sv/alg_pkg.sv
// ============================================================================
// alg_pkg: shared types and constants of the anti-aliased line generator
// Field widths, register indexes, controller/datapath interface structs and
// the color scaling function.
// ============================================================================
package alg_pkg;

    localparam int PIX_W       = 14;
    localparam int COLOR_W     = 8;
    localparam int WEIGHT_W    = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_FIELDS_W = 2 * PIX_W + 4 * COLOR_W;
    localparam int OUT_DATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd3;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_STEP = 1'b1;

    localparam logic [WEIGHT_W-1:0] WEIGHT_FULL = 8'd255;

    typedef struct packed {
        logic setup;
        logic div_step;
        logic finish;
        logic emit_near;
        logic emit_far;
    } t_cmd;

    typedef struct packed {
        logic line_active;
        logic out_free;
    } t_stat;

    // Color times weight divided by 255, truncated; exact for all 8-bit by 8-bit products.
    function automatic logic [COLOR_W-1:0] scale255(input logic [COLOR_W-1:0] c,
                                                    input logic [WEIGHT_W-1:0] w);
        logic [15:0] p;
        logic [16:0] s;
        p = 16'(c) * 16'(w);
        s = 17'(p) + 17'(p >> 8) + 17'd1;
        return s[15:8];
    endfunction

endpackage

### sv/alg_ctrl.sv
// ============================================================================
// alg_ctrl: sequencer of the anti-aliased line generator
// Accepts items, runs the gradient division iterations and orders the two
// pixel beats of each column.
// ============================================================================
module alg_ctrl import alg_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    input  logic  i_action,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_GRAD = 4'b0100,
        S_FAR  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             s_fire;

    assign o_s_tready = (r_state == S_IDLE) && i_stat.out_free;
    assign s_fire     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    if (i_action == ACT_LOAD) begin
                        o_cmd.setup = 1'b1;
                        n_cnt       = CNT_W'(FRAC_BITS);
                        n_state     = S_DIV;
                    end else if (i_stat.line_active) begin
                        o_cmd.emit_near = 1'b1;
                        n_state         = S_FAR;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_GRAD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_GRAD: begin
                o_cmd.finish = 1'b1;
                n_state      = S_IDLE;
            end
            S_FAR: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_far = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

### sv/alg_dp.sv
// ============================================================================
// alg_dp: datapath of the anti-aliased line generator
// Endpoint setup, restoring gradient divider, intercept accumulator, color
// scaling and the output register.
// ============================================================================
module alg_dp import alg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16,
    parameter int IN_DATA_W  = ((4 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COLOR_W-1:0]    i_cfg_data,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast,
    output logic                  o_m_tuser,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);

    localparam int CB = COORD_BITS;
    localparam int IW = COORD_BITS + 2;
    localparam int AW = IW + FRAC_BITS;
    localparam int GW = FRAC_BITS + 2;
    localparam int QW = FRAC_BITS + 1;
    localparam int RW = COORD_BITS + 1;

    logic [COLOR_W-1:0] r_red, r_green, r_blue, r_alpha;

    logic [CB-1:0] s_x0, s_y0, s_x1, s_y1, s_adx, s_ady;
    logic [CB-1:0] s_ma0, s_ma1, s_mi0, s_mi1, s_maj_lo, s_maj_hi, s_min_lo, s_min_hi;
    logic          s_steep, s_swap;

    logic                 r_line_active, r_steep, r_neg, r_dx_zero;
    logic [CB-1:0]        r_cur, r_last, r_dx;
    logic [RW-1:0]        r_rem, s_rem_sub;
    logic [QW-1:0]        r_quo;
    logic signed [GW-1:0] r_grad, s_grad;
    logic signed [AW-1:0] r_acc;

    logic signed [IW-1:0] s_ip, s_ip1, s_minor, s_major, s_px, s_py;
    logic signed [31:0]   s_px32, s_py32;
    logic [WEIGHT_W-1:0]  s_wfar, s_w;
    logic                 s_done, s_emit;

    logic                  r_out_valid, r_out_last, r_out_user;
    logic [OUT_DATA_W-1:0] r_out_data;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red   <= '0;
            r_green <= '0;
            r_blue  <= '0;
            r_alpha <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_RED:   r_red   <= i_cfg_data;
                CFG_GREEN: r_green <= i_cfg_data;
                CFG_BLUE:  r_blue  <= i_cfg_data;
                CFG_ALPHA: r_alpha <= i_cfg_data;
                default:   r_red   <= r_red;
            endcase
        end
    end

    // Endpoint setup: axis swap for steep lines, then order by major axis.
    always_comb begin
        s_x0    = i_s_tdata[CB-1:0];
        s_y0    = i_s_tdata[2*CB-1:CB];
        s_x1    = i_s_tdata[3*CB-1:2*CB];
        s_y1    = i_s_tdata[4*CB-1:3*CB];
        s_adx   = (s_x1 >= s_x0) ? s_x1 - s_x0 : s_x0 - s_x1;
        s_ady   = (s_y1 >= s_y0) ? s_y1 - s_y0 : s_y0 - s_y1;
        s_steep = s_ady > s_adx;
        s_ma0   = s_steep ? s_y0 : s_x0;
        s_mi0   = s_steep ? s_x0 : s_y0;
        s_ma1   = s_steep ? s_y1 : s_x1;
        s_mi1   = s_steep ? s_x1 : s_y1;
        s_swap  = s_ma0 > s_ma1;
        s_maj_lo = s_swap ? s_ma1 : s_ma0;
        s_maj_hi = s_swap ? s_ma0 : s_ma1;
        s_min_lo = s_swap ? s_mi1 : s_mi0;
        s_min_hi = s_swap ? s_mi0 : s_mi1;
    end

    assign s_rem_sub = r_rem - RW'(r_dx);
    assign s_grad    = r_dx_zero ? GW'(1) <<< FRAC_BITS
                     : (r_neg ? -$signed(GW'(r_quo)) : $signed(GW'(r_quo)));

    // Pixel of the current column.
    always_comb begin
        s_ip    = r_acc[AW-1:FRAC_BITS];
        s_ip1   = s_ip + IW'(1);
        s_wfar  = r_acc[FRAC_BITS-1 -: WEIGHT_W];
        s_minor = i_cmd.emit_far ? s_ip1 : s_ip;
        s_w     = i_cmd.emit_far ? s_wfar : WEIGHT_FULL - s_wfar;
        s_major = $signed({2'b00, r_cur});
        s_px    = r_steep ? s_minor : s_major;
        s_py    = r_steep ? s_major : s_minor;
        s_px32  = 32'(s_px);
        s_py32  = 32'(s_py);
        s_done  = r_cur == r_last;
        s_emit  = i_cmd.emit_near || i_cmd.emit_far;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_active <= 1'b0;
            r_steep       <= 1'b0;
            r_cur         <= '0;
            r_last        <= '0;
            r_acc         <= '0;
            r_grad        <= '0;
        end else begin
            if (i_cmd.setup) begin
                r_line_active <= 1'b0;
                r_steep       <= s_steep;
                r_cur         <= s_maj_lo;
                r_last        <= s_maj_hi;
                r_acc         <= $signed({2'b00, s_min_lo, FRAC_BITS'(0)});
            end
            if (i_cmd.finish) begin
                r_grad        <= s_grad;
                r_line_active <= 1'b1;
            end
            if (i_cmd.emit_far) begin
                if (s_done) begin
                    r_line_active <= 1'b0;
                end else begin
                    r_cur <= r_cur + 1'b1;
                    r_acc <= r_acc + AW'(r_grad);
                end
            end
        end
    end

    // Restoring divider: one quotient bit per step, integer bit first.
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_dx      <= s_maj_hi - s_maj_lo;
            r_dx_zero <= s_maj_hi == s_maj_lo;
            r_neg     <= s_min_lo > s_min_hi;
            r_rem     <= RW'((s_min_lo > s_min_hi) ? s_min_lo - s_min_hi
                                                   : s_min_hi - s_min_lo);
            r_quo     <= '0;
        end else if (i_cmd.div_step) begin
            if (r_rem >= RW'(r_dx)) begin
                r_quo <= {r_quo[QW-2:0], 1'b1};
                r_rem <= {s_rem_sub[RW-2:0], 1'b0};
            end else begin
                r_quo <= {r_quo[QW-2:0], 1'b0};
                r_rem <= {r_rem[RW-2:0], 1'b0};
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_emit) begin
            r_out_data <= OUT_DATA_W'({scale255(r_alpha, s_w), scale255(r_blue, s_w),
                                       scale255(r_green, s_w), scale255(r_red, s_w),
                                       s_py32[PIX_W-1:0], s_px32[PIX_W-1:0]});
            r_out_last <= i_cmd.emit_far;
            r_out_user <= s_done;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = r_out_user;

    assign o_stat.line_active = r_line_active;
    assign o_stat.out_free    = !r_out_valid || i_m_tready;

endmodule

### sv/antialiased_line_generator_unit.sv
// ============================================================================
// antialiased_line_generator_unit: Wu-style anti-aliased line generator
// Loads two endpoints, divides out the gradient, then emits two weighted,
// colored pixels per column step.
// ============================================================================
//  Channel  Direction  Beat contents
//  s        in         tdata: start_x, start_y, end_x, end_y; tuser: action
//  m        out        tdata: pixel_x, pixel_y, red, green, blue, alpha;
//                      tlast: pair_last; tuser: line_done
//  cfg      in         index 0..3 (red, green, blue, alpha), 8-bit data
//
// A step item emits its near and far pixel beats in turn through the output register.
// A load item runs the one-bit-per-cycle divider before the next item is accepted.
// Reset is synchronous and clears the line state and the color registers.
// A stalled output holds the far pixel and blocks the next input item.
module antialiased_line_generator_unit import alg_pkg::*; #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    // start_x, start_y, end_x, end_y from bit 0 up, zero padded
    input  logic [((4*COORD_BITS+7)/8)*8-1:0] i_s_tdata,
    // action
    input  logic                        i_s_tuser,
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    // pixel_x, pixel_y, red, green, blue, alpha from bit 0 up, zero padded
    output logic [OUT_DATA_W-1:0]       o_m_tdata,
    output logic                        o_m_tlast,
    // line_done
    output logic                        o_m_tuser,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [COLOR_W-1:0]          i_cfg_data
);

    localparam int IN_DATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    t_cmd  s_cmd;
    t_stat s_stat;

    assign o_cfg_ready = 1'b1;

    alg_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_action   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    alg_dp #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .IN_DATA_W  (IN_DATA_W)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .o_m_tuser   (o_m_tuser),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat)
    );

endmodule

### sim/tb.sv
// ============================================================================
// tb: self-checking testbench for antialiased_line_generator_unit
// Drives load and step beats with random gaps and stalls on both stream
// sides, predicts every pixel beat with an independent line tracer, and
// compares each output beat field by field in arrival order.
// ============================================================================
module tb;
    import alg_pkg::*;

    localparam int COORD_BITS  = 12;
    localparam int FRAC_BITS   = 16;
    localparam int IN_W        = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    localparam int SETTLE      = 2 * (FRAC_BITS + 3) + 4;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 85;
    localparam longint LIMIT_TIME = 64'd4_000_000;

    typedef struct {
        logic signed [PIX_W-1:0] px;
        logic signed [PIX_W-1:0] py;
        logic [COLOR_W-1:0]      red;
        logic [COLOR_W-1:0]      green;
        logic [COLOR_W-1:0]      blue;
        logic [COLOR_W-1:0]      alpha;
        logic                    pair_last;
        logic                    line_done;
    } t_pixel;

    class wu_pixel_tracker;
        logic [COLOR_W-1:0]    red, green, blue, alpha;
        bit                    line_on;
        bit                    steep;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] end_column;
        longint                acc;
        longint                slope;
        t_pixel                pending_pixels[$];
        int                    errors;

        function new();
            red = '0;
            green = '0;
            blue = '0;
            alpha = '0;
            line_on = 0;
            steep = 0;
            column = '0;
            end_column = '0;
            acc = 0;
            slope = 0;
            errors = 0;
        endfunction

        function void set_color(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] val);
            case (idx)
                CFG_RED: red = val;
                CFG_GREEN: green = val;
                CFG_BLUE: blue = val;
                CFG_ALPHA: alpha = val;
                default: ;
            endcase
        endfunction

        function logic [COLOR_W-1:0] shade(logic [COLOR_W-1:0] c, int w);
            int p;
            p = (int'(c) * w) / 255;
            return p[COLOR_W-1:0];
        endfunction

        function void queue_pixel(longint major, longint minor, int w, bit last, bit done);
            t_pixel p;
            longint x;
            longint y;
            x = steep ? minor : major;
            y = steep ? major : minor;
            p.px = x[PIX_W-1:0];
            p.py = y[PIX_W-1:0];
            p.red = shade(red, w);
            p.green = shade(green, w);
            p.blue = shade(blue, w);
            p.alpha = shade(alpha, w);
            p.pair_last = last;
            p.line_done = done;
            pending_pixels.push_back(p);
        endfunction

        // Returns the number of pixel beats that the item causes.
        function int take_item(logic act, logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                               logic [COORD_BITS-1:0] ex, logic [COORD_BITS-1:0] ey);
            longint x0, y0, x1, y1, t, dx, dy, adx, ady, q, ip;
            int wfar;
            bit done;
            if (act == ACT_LOAD) begin
                x0 = sx;
                y0 = sy;
                x1 = ex;
                y1 = ey;
                adx = x1 >= x0 ? x1 - x0 : x0 - x1;
                ady = y1 >= y0 ? y1 - y0 : y0 - y1;
                steep = ady > adx;
                if (steep) begin
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1) begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                dx = x1 - x0;
                dy = y1 - y0;
                if (dx == 0) begin
                    slope = longint'(1) << FRAC_BITS;
                end else begin
                    q = ((dy < 0 ? -dy : dy) << FRAC_BITS) / dx;
                    slope = dy < 0 ? -q : q;
                end
                acc = y0 << FRAC_BITS;
                column = x0[COORD_BITS-1:0];
                end_column = x1[COORD_BITS-1:0];
                line_on = 1;
                return 0;
            end
            if (!line_on)
                return 0;
            ip = acc >>> FRAC_BITS;
            wfar = int'(acc[FRAC_BITS-1:FRAC_BITS-8]);
            done = column == end_column;
            queue_pixel(longint'(column), ip, 255 - wfar, 1'b0, done);
            queue_pixel(longint'(column), ip + 1, wfar, 1'b1, done);
            if (done) begin
                line_on = 0;
            end else begin
                column = column + 1'b1;
                acc = acc + slope;
            end
            return 2;
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (pending_pixels.size() == 0) begin
                $error("pixel beat (%0d, %0d) arrived with none outstanding", got.px, got.py);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            check_field("pixel_x", int'(want.px), int'(got.px));
            check_field("pixel_y", int'(want.py), int'(got.py));
            check_field("out_red", want.red, got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue", want.blue, got.blue);
            check_field("out_alpha", want.alpha, got.alpha);
            check_field("pair_last", want.pair_last, got.pair_last);
            check_field("line_done", want.line_done, got.line_done);
        endfunction

        function int outstanding();
            return pending_pixels.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_W-1:0]        i_s_tdata;
    logic                   i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;
    logic                   o_m_tlast;
    logic                   o_m_tuser;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [COLOR_W-1:0]     i_cfg_data;

    wu_pixel_tracker tracker;
    bit tx_idle;
    bit rx_idle;
    bit hold_req;
    int counted;

    antialiased_line_generator_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(LIMIT_TIME);
        $display("** antialiased_line_generator_unit: FAILED **");
        $finish;
    end

    always @(posedge i_clk) begin
        t_pixel got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.px = o_m_tdata[13:0];
            got.py = o_m_tdata[27:14];
            got.red = o_m_tdata[35:28];
            got.green = o_m_tdata[43:36];
            got.blue = o_m_tdata[51:44];
            got.alpha = o_m_tdata[59:52];
            got.pair_last = o_m_tlast;
            got.line_done = o_m_tuser;
            tracker.check_pixel(got);
        end
    end

    initial begin : receiver
        int gap;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                gap = rx_idle ? $urandom_range(6, 0) : 0;
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (o_m_tvalid !== 1'b1);
        end
    end

    task automatic send_item(input logic act, input int sx, input int sy,
                             input int ex, input int ey);
        int gap;
        gap = tx_idle ? $urandom_range(6, 0) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {ey[COORD_BITS-1:0], ex[COORD_BITS-1:0],
                      sy[COORD_BITS-1:0], sx[COORD_BITS-1:0]};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        void'(tracker.take_item(act, sx[COORD_BITS-1:0], sy[COORD_BITS-1:0],
                                ex[COORD_BITS-1:0], ey[COORD_BITS-1:0]));
        counted++;
    endtask

    task automatic load_line(input int sx, input int sy, input int ex, input int ey);
        send_item(ACT_LOAD, sx, sy, ex, ey);
    endtask

    task automatic step_line(input int n);
        repeat (n) begin
            send_item(ACT_STEP, $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                      $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
        end
    endtask

    task automatic drain_pixels();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_color(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.set_color(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_palette(input int r, input int g, input int b, input int a);
        write_color(CFG_RED, r[COLOR_W-1:0]);
        write_color(CFG_GREEN, g[COLOR_W-1:0]);
        write_color(CFG_BLUE, b[COLOR_W-1:0]);
        write_color(CFG_ALPHA, a[COLOR_W-1:0]);
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int edge_coord();
        case ($urandom_range(3, 0))
            0: return $urandom_range(3, 0);
            1: return COORD_MAX - $urandom_range(3, 0);
            default: return $urandom_range(COORD_MAX, 0);
        endcase
    endfunction

    task automatic random_line();
        int sx, sy, ex, ey, span, steps;
        sx = edge_coord();
        sy = edge_coord();
        case ($urandom_range(9, 0))
            6: begin
                load_line(sx, sy, $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
                step_line($urandom_range(6, 1));
            end
            7: load_line($urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0),
                         $urandom_range(COORD_MAX, 0), $urandom_range(COORD_MAX, 0));
            8: step_line($urandom_range(3, 1));
            default: begin
                ex = clamp_coord(sx + $urandom_range(24, 0) - 12);
                ey = clamp_coord(sy + $urandom_range(24, 0) - 12);
                span = (ex > sx ? ex - sx : sx - ex);
                if ((ey > sy ? ey - sy : sy - ey) > span)
                    span = ey > sy ? ey - sy : sy - ey;
                if ($urandom_range(7, 0) == 0)
                    steps = $urandom_range(span, 0);
                else
                    steps = span + 1 + $urandom_range(2, 0);
                load_line(sx, sy, ex, ey);
                step_line(steps);
            end
        endcase
    endtask

    initial begin
        int phase;
        tracker = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = ACT_LOAD;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_RED;
        i_cfg_data = '0;
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_req = 1'b0;
        counted = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE) @(posedge i_clk);

        set_palette(255, 0, 1, 128);
        step_line(1);
        load_line(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        step_line(2);
        load_line(0, 0, COORD_MAX, COORD_MAX);
        step_line(2);
        load_line(COORD_MAX, 0, 0, 3);
        step_line(3);
        load_line(5, 2, 5, 0);
        step_line(4);
        load_line(0, COORD_MAX, 3, COORD_MAX - 7);
        step_line(3);
        load_line(COORD_MAX, 7, COORD_MAX - 2, 7);
        step_line(3);
        drain_pixels();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_palette(0, 0, 0, 0);
                1: set_palette(255, 255, 255, 255);
                default: set_palette($urandom_range(255, 0), $urandom_range(255, 0),
                                     $urandom_range(255, 0), $urandom_range(255, 0));
            endcase
            tx_idle = phase[0];
            rx_idle = phase[1] | phase[2];
            if (phase == 2)
                hold_req = 1'b1;
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                random_line();
                if (phase == 3 && counted >= PHASE_ITEMS / 2 && counted < PHASE_ITEMS / 2 + 3)
                    drain_pixels();
            end
            drain_pixels();
        end

        if (tracker.errors == 0) begin
            $display("** antialiased_line_generator_unit: PASSED **");
        end else begin
            $display("** antialiased_line_generator_unit: FAILED **");
        end
        $finish;
    end
endmodule

### antialiased_line_generator_unit.f
sv/alg_pkg.sv
sv/alg_ctrl.sv
sv/alg_dp.sv
sv/antialiased_line_generator_unit.sv
sim/tb.sv
